>>> rtl/tmrd_pkg.sv
package tmrd_pkg;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FIRST    = 2'd1;
   localparam logic [1:0] STATUS_INACTIVE = 2'd2;
   localparam logic [1:0] STATUS_ZERO     = 2'd3;

   localparam logic [23:0] MAX24 = 24'hFF_FFFF;

   typedef struct packed {
      logic [1:0]  group_index;
      logic [7:0]  cell_index;
      logic [23:0] flux_sample;
      logic [15:0] generation;
   } req_type;

   typedef struct packed {
      logic [1:0]  out_group;
      logic [7:0]  out_cell;
      logic [23:0] mean_flux;
      logic [23:0] relative_deviation;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic        active;
      logic [15:0] n;
      logic [1:0]  group_index;
      logic [7:0]  cell_index;
      logic [39:0] sum;
      logic [63:0] square_sum;
   } acc_out_type;

endpackage

>>> rtl/tmrd_div_pipe.sv
module tmrd_div_pipe import tmrd_pkg::*; #(
   parameter int DW = 64,
   parameter int VW = 16,
   parameter int TW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          valid_in,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   input  logic [TW-1:0] tag_in,
   output logic          valid_out,
   output logic [DW-1:0] quotient,
   output logic [TW-1:0] tag_out
);

   logic [VW-1:0] rem_ff  [DW];
   logic [DW-1:0] quo_ff  [DW];
   logic [VW-1:0] dvs_ff  [DW];
   logic [TW-1:0] tag_ff  [DW];
   logic          valid_ff [DW];

   logic [VW-1:0] rem_in  [DW];
   logic [DW-1:0] quo_in  [DW];

   logic [VW-1:0] rem_src [DW];
   logic [DW-1:0] quo_src [DW];
   logic [VW-1:0] dvs_src [DW];
   logic [TW-1:0] tag_src [DW];
   logic          valid_src [DW];

   for (genvar k = 0; k < DW; k++) begin : g_src
      if (k == 0) begin : g_first
         assign rem_src[k]   = '0;
         assign quo_src[k]   = dividend;
         assign dvs_src[k]   = divisor;
         assign tag_src[k]   = tag_in;
         assign valid_src[k] = valid_in;
      end else begin : g_next
         assign rem_src[k]   = rem_ff[k-1];
         assign quo_src[k]   = quo_ff[k-1];
         assign dvs_src[k]   = dvs_ff[k-1];
         assign tag_src[k]   = tag_ff[k-1];
         assign valid_src[k] = valid_ff[k-1];
      end
   end

   always_comb begin
      logic [VW:0] trial;
      logic        take;
      for (int k = 0; k < DW; k++) begin
         trial = {rem_src[k], quo_src[k][DW-1]};
         take  = trial >= {1'b0, dvs_src[k]};
         rem_in[k] = take ? VW'(trial - {1'b0, dvs_src[k]}) : trial[VW-1:0];
         quo_in[k] = {quo_src[k][DW-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DW; k++) begin
         rem_ff[k] <= rem_in[k];
         quo_ff[k] <= quo_in[k];
         dvs_ff[k] <= dvs_src[k];
         tag_ff[k] <= tag_src[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DW; k++) valid_ff[k] <= 1'b0;
      end else begin
         for (int k = 0; k < DW; k++) valid_ff[k] <= valid_src[k];
      end
   end

   assign valid_out = valid_ff[DW-1];
   assign quotient  = quo_ff[DW-1];
   assign tag_out   = tag_ff[DW-1];

endmodule

>>> rtl/tmrd_sqrt_pipe.sv
module tmrd_sqrt_pipe import tmrd_pkg::*; #(
   parameter int XW = 64,
   parameter int TW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            valid_in,
   input  logic [XW-1:0]   radicand,
   input  logic [TW-1:0]   tag_in,
   output logic            valid_out,
   output logic [XW/2-1:0] root,
   output logic [TW-1:0]   tag_out
);

   localparam int RW = XW / 2;

   logic [RW:0]   rem_ff  [RW];
   logic [RW-1:0] root_ff [RW];
   logic [XW-1:0] x_ff    [RW];
   logic [TW-1:0] tag_ff  [RW];
   logic          valid_ff [RW];

   logic [RW:0]   rem_in  [RW];
   logic [RW-1:0] root_in [RW];

   logic [RW:0]   rem_src  [RW];
   logic [RW-1:0] root_src [RW];
   logic [XW-1:0] x_src    [RW];
   logic [TW-1:0] tag_src  [RW];
   logic          valid_src [RW];

   for (genvar k = 0; k < RW; k++) begin : g_src
      if (k == 0) begin : g_first
         assign rem_src[k]   = '0;
         assign root_src[k]  = '0;
         assign x_src[k]     = radicand;
         assign tag_src[k]   = tag_in;
         assign valid_src[k] = valid_in;
      end else begin : g_next
         assign rem_src[k]   = rem_ff[k-1];
         assign root_src[k]  = root_ff[k-1];
         assign x_src[k]     = x_ff[k-1];
         assign tag_src[k]   = tag_ff[k-1];
         assign valid_src[k] = valid_ff[k-1];
      end
   end

   always_comb begin
      logic [RW+2:0] trial;
      logic [RW+2:0] sub;
      logic          take;
      for (int k = 0; k < RW; k++) begin
         trial = {rem_src[k], x_src[k][XW-1:XW-2]};
         sub   = {1'b0, root_src[k], 2'b01};
         take  = trial >= sub;
         rem_in[k]  = take ? (RW+1)'(trial - sub) : trial[RW:0];
         root_in[k] = {root_src[k][RW-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < RW; k++) begin
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
         x_ff[k]    <= {x_src[k][XW-3:0], 2'b00};
         tag_ff[k]  <= tag_src[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < RW; k++) valid_ff[k] <= 1'b0;
      end else begin
         for (int k = 0; k < RW; k++) valid_ff[k] <= valid_src[k];
      end
   end

   assign valid_out = valid_ff[RW-1];
   assign root      = root_ff[RW-1];
   assign tag_out   = tag_ff[RW-1];

endmodule

>>> rtl/tmrd_acc.sv
module tmrd_acc import tmrd_pkg::*; #(
   parameter int GROUPS = 4,
   parameter int CELLS  = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  req_type     in_data,
   input  logic [15:0] inactive,
   output logic        clearing,
   output acc_out_type acc_out
);

   localparam int BINS    = GROUPS * CELLS;
   localparam int GROUP_W = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int CELL_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int BIN_W   = (BINS > 1) ? $clog2(BINS) : 1;

   logic [39:0] sum_mem    [BINS];
   logic [63:0] square_mem [BINS];

   logic [GROUP_W-1:0] group_mod [4];
   logic [CELL_W-1:0]  cell_mod  [256];

   for (genvar i = 0; i < 4; i++) begin : g_group_mod
      assign group_mod[i] = GROUP_W'(i % GROUPS);
   end
   for (genvar i = 0; i < 256; i++) begin : g_cell_mod
      assign cell_mod[i] = CELL_W'(i % CELLS);
   end

   logic             clear_ff;
   logic [BIN_W-1:0] clear_addr_ff;

   logic        v0_ff;
   req_type     req0_ff;
   logic        active0;
   logic [15:0] n0;
   logic [BIN_W-1:0] bin0;

   logic        v1_ff, active1_ff;
   logic [15:0] n1_ff;
   logic [BIN_W-1:0] bin1_ff;
   logic [47:0] sq1_ff;
   logic [23:0] sample1_ff;
   logic [1:0]  group1_ff;
   logic [7:0]  cell1_ff;
   logic [39:0] rd_sum_ff;
   logic [63:0] rd_square_ff;

   logic        v2_ff, active2_ff, wr2_ff;
   logic [15:0] n2_ff;
   logic [BIN_W-1:0] bin2_ff;
   logic [1:0]  group2_ff;
   logic [7:0]  cell2_ff;
   logic [39:0] sum2_ff;
   logic [63:0] square2_ff;

   logic [39:0] base_sum, sum_in;
   logic [63:0] base_square, square_in;
   logic [40:0] sum_wide;
   logic [64:0] square_wide;
   logic        hit, wr1;

   assign active0 = req0_ff.generation > inactive;
   assign n0      = req0_ff.generation - inactive;
   assign bin0    = BIN_W'(int'(group_mod[req0_ff.group_index]) * CELLS
                    + int'(cell_mod[req0_ff.cell_index]));

   assign hit         = wr2_ff && (bin2_ff == bin1_ff);
   assign base_sum    = hit ? sum2_ff : rd_sum_ff;
   assign base_square = hit ? square2_ff : rd_square_ff;
   assign sum_wide    = {1'b0, base_sum} + {17'd0, sample1_ff};
   assign square_wide = {1'b0, base_square} + {17'd0, sq1_ff};
   assign sum_in      = sum_wide[40] ? '1 : sum_wide[39:0];
   assign square_in   = square_wide[64] ? '1 : square_wide[63:0];
   assign wr1         = v1_ff && active1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         v0_ff         <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         wr2_ff        <= 1'b0;
      end else begin
         if (clear_ff) begin
            clear_addr_ff <= clear_addr_ff + 1'b1;
            if (clear_addr_ff == BIN_W'(BINS - 1)) clear_ff <= 1'b0;
         end
         v0_ff  <= in_valid;
         v1_ff  <= v0_ff;
         v2_ff  <= v1_ff;
         wr2_ff <= wr1;
      end
   end

   always_ff @(posedge clock) begin
      req0_ff      <= in_data;
      rd_sum_ff    <= sum_mem[bin0];
      rd_square_ff <= square_mem[bin0];
      active1_ff   <= active0;
      n1_ff        <= n0;
      bin1_ff      <= bin0;
      sq1_ff       <= req0_ff.flux_sample * req0_ff.flux_sample;
      sample1_ff   <= req0_ff.flux_sample;
      group1_ff    <= req0_ff.group_index;
      cell1_ff     <= req0_ff.cell_index;
      active2_ff   <= active1_ff;
      n2_ff        <= n1_ff;
      bin2_ff      <= bin1_ff;
      group2_ff    <= group1_ff;
      cell2_ff     <= cell1_ff;
      sum2_ff      <= sum_in;
      square2_ff   <= square_in;
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         sum_mem[clear_addr_ff]    <= '0;
         square_mem[clear_addr_ff] <= '0;
      end else if (wr1) begin
         sum_mem[bin1_ff]    <= sum_in;
         square_mem[bin1_ff] <= square_in;
      end
   end

   assign clearing = clear_ff;

   assign acc_out = '{valid:       v2_ff,
                      active:      active2_ff,
                      n:           n2_ff,
                      group_index: group2_ff,
                      cell_index:  cell2_ff,
                      sum:         sum2_ff,
                      square_sum:  square2_ff};

endmodule

>>> rtl/tally_mean_relative_deviation.sv
// Channel  Ports                                  Handshake
// request  start, busy, req_data                  beat taken when start and not busy
// result   rsp_valid, rsp_data                    one-cycle strobe, cannot be held off
// config   csr_valid, csr_ready, csr_wdata        beat taken when valid and ready
//
// One item may enter every cycle while busy is low; its result strobe rises once the item
// has passed three tally stages, a 64-stage divider (mean and mean square side by
// side), three arithmetic stages, a 64-stage variance divider, the 32-stage square root,
// a 48-stage divider and the output register.
// After reset busy stays high while every bin of the tally store is cleared.
// Results cannot be stalled, so the pipeline always advances and busy falls for good.
module tally_mean_relative_deviation import tmrd_pkg::*; #(
   parameter int GROUPS = 4,
   parameter int CELLS  = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata
);

   typedef struct packed {
      logic       active;
      logic       first;
      logic [1:0] group_index;
      logic [7:0] cell_index;
   } meta_type;

   typedef struct packed {
      meta_type    meta;
      logic [23:0] mean;
   } tail_type;

   logic [15:0] inactive_ff;
   acc_out_type acc_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         inactive_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         inactive_ff <= csr_wdata;
      end
   end

   assign csr_ready = 1'b1;

   tmrd_acc #(.GROUPS(GROUPS), .CELLS(CELLS)) u_acc (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .in_data  (req_data),
      .inactive (inactive_ff),
      .clearing (busy),
      .acc_out  (acc_out)
   );

   meta_type    meta_a, meta_d;
   logic        mean_v, ms_v;
   logic [63:0] mean_q, ms_q;
   logic [15:0] nm1_d;

   assign meta_a = '{active:      acc_out.active,
                     first:       acc_out.n == 16'd1,
                     group_index: acc_out.group_index,
                     cell_index:  acc_out.cell_index};

   tmrd_div_pipe #(.DW(64), .VW(16), .TW($bits(meta_type))) u_mean_div (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (acc_out.valid),
      .dividend  ({24'd0, acc_out.sum}),
      .divisor   (acc_out.n),
      .tag_in    (meta_a),
      .valid_out (mean_v),
      .quotient  (mean_q),
      .tag_out   (meta_d)
   );

   tmrd_div_pipe #(.DW(64), .VW(16), .TW(16)) u_ms_div (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (acc_out.valid),
      .dividend  (acc_out.square_sum),
      .divisor   (acc_out.n),
      .tag_in    (acc_out.n - 16'd1),
      .valid_out (ms_v),
      .quotient  (ms_q),
      .tag_out   (nm1_d)
   );

   logic        p1_v_ff, p2_v_ff, p3_v_ff;
   meta_type    p1_meta_ff, p2_meta_ff, p3_meta_ff;
   logic [23:0] p1_mean_ff, p2_mean_ff, p3_mean_ff;
   logic [63:0] p1_ms_ff, p2_ms_ff, p3_var_ff;
   logic [15:0] p1_nm1_ff, p2_nm1_ff, p3_nm1_ff;
   logic [47:0] p2_m2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
      end else begin
         p1_v_ff <= mean_v && ms_v;
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_meta_ff <= meta_d;
      p1_mean_ff <= (mean_q[63:24] != '0) ? MAX24 : mean_q[23:0];
      p1_ms_ff   <= ms_q;
      p1_nm1_ff  <= nm1_d;
      p2_meta_ff <= p1_meta_ff;
      p2_mean_ff <= p1_mean_ff;
      p2_ms_ff   <= p1_ms_ff;
      p2_nm1_ff  <= p1_nm1_ff;
      p2_m2_ff   <= p1_mean_ff * p1_mean_ff;
      p3_meta_ff <= p2_meta_ff;
      p3_mean_ff <= p2_mean_ff;
      p3_nm1_ff  <= p2_nm1_ff;
      p3_var_ff  <= (p2_ms_ff > {16'd0, p2_m2_ff}) ? p2_ms_ff - {16'd0, p2_m2_ff} : '0;
   end

   logic        var_v, sqrt_v, rel_v;
   logic [63:0] var_q;
   logic [31:0] sd;
   logic [47:0] rel_q;
   tail_type    tail_var, tail_sqrt, tail_rel;

   tmrd_div_pipe #(.DW(64), .VW(16), .TW($bits(tail_type))) u_var_div (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (p3_v_ff),
      .dividend  (p3_var_ff),
      .divisor   (p3_nm1_ff),
      .tag_in    ({p3_meta_ff, p3_mean_ff}),
      .valid_out (var_v),
      .quotient  (var_q),
      .tag_out   (tail_var)
   );

   tmrd_sqrt_pipe #(.XW(64), .TW($bits(tail_type))) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (var_v),
      .radicand  (var_q),
      .tag_in    (tail_var),
      .valid_out (sqrt_v),
      .root      (sd),
      .tag_out   (tail_sqrt)
   );

   tmrd_div_pipe #(.DW(48), .VW(24), .TW($bits(tail_type))) u_rel_div (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (sqrt_v),
      .dividend  ({sd, 16'd0}),
      .divisor   (tail_sqrt.mean),
      .tag_in    (tail_sqrt),
      .valid_out (rel_v),
      .quotient  (rel_q),
      .tag_out   (tail_rel)
   );

   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   rsp_type     rsp_data_in;

   always_comb begin
      rsp_data_in.out_group          = tail_rel.meta.group_index;
      rsp_data_in.out_cell           = tail_rel.meta.cell_index;
      rsp_data_in.mean_flux          = tail_rel.mean;
      rsp_data_in.relative_deviation = '0;
      if (!tail_rel.meta.active) begin
         rsp_data_in.mean_flux = '0;
         rsp_data_in.status    = STATUS_INACTIVE;
      end else if (tail_rel.mean == '0) begin
         rsp_data_in.status    = STATUS_ZERO;
      end else if (tail_rel.meta.first) begin
         rsp_data_in.status    = STATUS_FIRST;
      end else begin
         rsp_data_in.relative_deviation = (rel_q[47:24] != '0) ? MAX24 : rel_q[23:0];
         rsp_data_in.status             = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rel_v;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> tb/sv/tally_mean_relative_deviation_test.sv
`timescale 1ns / 100ps

module tally_mean_relative_deviation_test;
   import tmrd_pkg::*;

   localparam int BIN_COUNT = 4 * 256;
   localparam logic [63:0] SUM_LIMIT = 64'hFF_FFFF_FFFF;
   localparam int DRAIN_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_wdata = '0;

   logic [63:0] bin_sum [BIN_COUNT];
   logic [63:0] bin_square_sum [BIN_COUNT];
   logic [15:0] inactive_count;
   rsp_type     pending_tallies [$];
   int          error_count = 0;
   int          burst_left = 0;

   tally_mean_relative_deviation dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] square_root(input logic [63:0] value);
      logic [63:0] root;
      logic [63:0] bit_mask;
      root = 0;
      bit_mask = 64'd1 << 62;
      while (bit_mask > value) bit_mask = bit_mask >> 2;
      while (bit_mask != 0) begin
         if (value >= root + bit_mask) begin
            value = value - (root + bit_mask);
            root = (root >> 1) + bit_mask;
         end else begin
            root = root >> 1;
         end
         bit_mask = bit_mask >> 2;
      end
      return root;
   endfunction

   function automatic rsp_type tally_update(input req_type item);
      rsp_type     result;
      logic [63:0] n, square, total, ms, m2, variance, sd, mean, rel;
      logic [64:0] square_total;
      int          bin;
      result = '0;
      result.out_group = item.group_index;
      result.out_cell = item.cell_index;
      mean = 0;
      rel = 0;
      if (item.generation <= inactive_count) begin
         result.status = STATUS_INACTIVE;
      end else begin
         n = item.generation - inactive_count;
         bin = item.group_index * 256 + item.cell_index;
         square = 64'(item.flux_sample) * 64'(item.flux_sample);
         total = bin_sum[bin] + item.flux_sample;
         if (total > SUM_LIMIT) total = SUM_LIMIT;
         square_total = {1'b0, bin_square_sum[bin]} + {1'b0, square};
         bin_sum[bin] = total;
         bin_square_sum[bin] = square_total[64] ? '1 : square_total[63:0];
         mean = total / n;
         if (mean > MAX24) mean = MAX24;
         if (mean == 0) begin
            result.status = STATUS_ZERO;
         end else if (n == 1) begin
            result.status = STATUS_FIRST;
         end else begin
            ms = bin_square_sum[bin] / n;
            m2 = mean * mean;
            variance = (ms > m2) ? ms - m2 : 0;
            variance = variance / (n - 1);
            sd = square_root(variance);
            rel = (sd << 16) / mean;
            if (rel > MAX24) rel = MAX24;
            result.status = STATUS_OK;
         end
      end
      result.mean_flux = mean[23:0];
      result.relative_deviation = rel[23:0];
      return result;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_tallies.size() == 0) begin
            $display("%0t: unexpected result, actual %p", $time, rsp_data);
            error_count++;
         end else begin
            if (rsp_data !== pending_tallies[0]) begin
               $display("%0t: mismatch, expected %p, actual %p", $time,
                        pending_tallies[0], rsp_data);
               error_count++;
            end
            void'(pending_tallies.pop_front());
         end
      end
   end

   task automatic send_item(input req_type item);
      int      gap;
      rsp_type predicted;
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      predicted = tally_update(item);
      pending_tallies.insert(pending_tallies.size(), predicted);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 20);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_fields(input int grp, input int cell_no, input int sample,
                              input int gen);
      req_type item;
      item.group_index = 2'(grp);
      item.cell_index = 8'(cell_no);
      item.flux_sample = 24'(sample);
      item.generation = 16'(gen);
      send_item(item);
   endtask

   // The register is only written once the pipeline has drained.
   task automatic write_inactive(input logic [15:0] value);
      start <= 1'b0;
      @(posedge clock);
      while (pending_tallies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      inactive_count = value;
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed();
      write_inactive(16'd0);
      send_fields(0, 0, 100, 0);
      send_fields(1, 1, 0, 1);
      send_fields(3, 255, 24'hFF_FFFF, 1);
      send_fields(3, 255, 24'hFF_FFFF, 1);
      send_fields(3, 255, 0, 2);
      send_fields(2, 7, 24'h01_0000, 1);
      send_fields(2, 7, 24'h03_0000, 2);
      send_fields(2, 7, 24'h02_0000, 3);
      send_fields(0, 9, 24'hFF_FFFF, 16'hFFFF);
      send_fields(0, 10, 1, 16'hFFFF);
      send_fields(0, 11, 5, 2);
      send_fields(0, 11, 0, 3);
      write_inactive(16'd65534);
      send_fields(1, 20, 24'h12_3456, 16'hFFFE);
      send_fields(1, 20, 24'h12_3456, 16'hFFFF);
      send_fields(1, 21, 0, 16'hFFFF);
      send_fields(1, 22, 24'hFF_FFFF, 0);
   endtask

   task automatic test_random();
      logic [15:0] setting;
      int          phase, k, base, grp, cell_no;
      for (phase = 0; phase < 10; phase++) begin
         case (phase % 4)
            0: setting = 16'd0;
            1: setting = 16'd65534;
            default: setting = 16'($urandom_range(0, 65534));
         endcase
         if (phase % 4 == 2) setting = 16'($urandom_range(0, 40));
         write_inactive(setting);
         base = $urandom_range(0, 1023);
         for (k = 0; k < 110; k++) begin
            if ($urandom_range(0, 9) < 8) begin
               grp = base[9:8] ^ $urandom_range(0, 1);
               cell_no = base[7:0] + $urandom_range(0, 3);
               send_fields(grp, cell_no & 8'hFF,
                           $urandom_range(0, 3) == 0 ? $urandom_range(0, 24'hFF_FFFF)
                                                     : $urandom_range(0, 24'h04_0000),
                           (int'(setting) + $urandom_range(0, 30)) & 16'hFFFF);
            end else begin
               send_fields($urandom_range(0, 3), $urandom_range(0, 255),
                           $urandom_range(0, 24'hFF_FFFF), $urandom_range(0, 16'hFFFF));
            end
         end
      end
   endtask

   initial begin
      for (int i = 0; i < BIN_COUNT; i++) begin
         bin_sum[i] = 0;
         bin_square_sum[i] = 0;
      end
      inactive_count = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random();
      start <= 1'b0;
      while (pending_tallies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tally_mean_relative_deviation_test passed");
      end else begin
         $display("tally_mean_relative_deviation_test failed");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tally_mean_relative_deviation_test failed");
      $finish;
   end

endmodule
